// File: sv/mrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response checker package
// Shared constants, status codes, the frame snapshot type and the byte-wise
// CRC-16/Modbus update used by the checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_CRC_ERR   = 2'd2;
    localparam logic [1:0] ST_COUNT_ERR = 2'd3;

    // CRC-16/Modbus constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Shortest valid response frame, in bytes.
    localparam int unsigned MIN_FRAME = 8;

    // Ten-thousandths scale applied to the integer word.
    localparam logic [13:0] SCALE = 14'd10000;

    // Frame state as it stands after the byte in stage one is taken in.
    typedef struct packed {
        logic [15:0]      crc;
        logic [7:0]       held_lo;
        logic [7:0]       held_hi;
        logic [7:0]       count;
        logic [3:0][7:0]  data;
        logic             short_frame;
    } t_frame_snap;

    // One byte through the reflected CRC-16/Modbus polynomial.
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// File: sv/mrc_frame_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU frame tracker
// Holds the running CRC, the two-byte delay line, the saturating byte counter
// and the captured count and data bytes of the frame in progress.
// ----------------------------------------------------------------------------
module mrc_frame_track #(
    parameter int MAX_FRAME = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output mrc_pkg::t_frame_snap o_snap
);

    localparam int IDX_W = $clog2(MAX_FRAME + 1);

    logic [15:0]      r_crc,     n_crc;
    logic [7:0]       r_held_lo, n_held_lo;
    logic [7:0]       r_held_hi, n_held_hi;
    logic [IDX_W-1:0] r_index,   n_index;
    logic [7:0]       r_count,   n_count;
    logic [3:0][7:0]  r_data,    n_data;
    logic [IDX_W-1:0] data_off;

    assign data_off = r_index - IDX_W'(3);

    // Next frame state for the byte in hand.
    always_comb begin
        n_crc     = r_crc;
        n_count   = r_count;
        n_data    = r_data;
        n_index   = r_index;
        // The byte leaving the full delay line enters the CRC.
        if (r_index >= IDX_W'(2)) begin
            n_crc = mrc_pkg::crc_update(r_crc, r_held_lo);
        end
        n_held_lo = r_held_hi;
        n_held_hi = i_byte;
        if (r_index == IDX_W'(2)) begin
            n_count = i_byte;
        end else if (r_index >= IDX_W'(3) && r_index <= IDX_W'(6)) begin
            n_data[data_off[1:0]] = i_byte;
        end
        if (r_index < IDX_W'(MAX_FRAME)) begin
            n_index = r_index + IDX_W'(1);
        end
    end

    // Snapshot handed to the result logic on the last byte.
    always_comb begin
        o_snap.crc         = n_crc;
        o_snap.held_lo     = n_held_lo;
        o_snap.held_hi     = n_held_hi;
        o_snap.count       = n_count;
        o_snap.data        = n_data;
        o_snap.short_frame = (n_index < IDX_W'(mrc_pkg::MIN_FRAME));
    end

    // Frame state clears on reset and after each last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= mrc_pkg::CRC_INIT;
            r_held_lo <= '0;
            r_held_hi <= '0;
            r_index   <= '0;
            r_count   <= '0;
            r_data    <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_crc     <= mrc_pkg::CRC_INIT;
                r_held_lo <= '0;
                r_held_hi <= '0;
                r_index   <= '0;
                r_count   <= '0;
                r_data    <= '0;
            end else begin
                r_crc     <= n_crc;
                r_held_lo <= n_held_lo;
                r_held_hi <= n_held_hi;
                r_index   <= n_index;
                r_count   <= n_count;
                r_data    <= n_data;
            end
        end
    end

endmodule

// File: sv/modbus_rtu_response_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response checker
// Checks one Modbus RTU response frame byte by byte and reports its status,
// data words, scaled value and computed CRC on the last byte.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle with no gaps required, unless a
// last byte waits on a busy result register: each accepted byte is
// registered, then the tracker folds it into the CRC, so the sustained rate
// is one byte per clock, set by the byte-wide CRC update. The result beat for
// a frame is loaded into the result register when its last byte leaves the
// input register, which is later if an earlier result is still waiting, and
// stays until taken; while it waits, further bytes keep flowing until another
// last byte needs the output register. No clearing pass is needed after reset.
module modbus_rtu_response_checker_unit #(
    parameter int MAX_FRAME = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_integer_word,
    output logic [15:0] o_fraction_word,
    output logic [29:0] o_scaled_value,
    output logic [15:0] o_computed_crc,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_expected_count
);

    logic                 r_s1_valid;
    logic [7:0]           r_s1_byte;
    logic                 r_s1_last;
    logic                 s1_fire;
    logic                 out_free;
    logic [7:0]           r_expected_count;
    mrc_pkg::t_frame_snap snap;
    logic [1:0]           n_status;
    logic [15:0]          n_iw;
    logic [15:0]          n_fw;
    logic [29:0]          n_scaled;

    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic [15:0]          r_integer_word;
    logic [15:0]          r_fraction_word;
    logic [29:0]          r_scaled_value;
    logic [15:0]          r_computed_crc;

    // Stage one advances unless a last byte finds the output register busy.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && (!r_s1_last || out_free);
    assign o_in_ready = !r_s1_valid || s1_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_byte <= i_rx_byte;
            r_s1_last <= i_frame_end;
        end
    end

    // Configuration register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_count <= 8'd4;
        end else if (i_cfg_valid) begin
            r_expected_count <= i_cfg_expected_count;
        end
    end

    mrc_frame_track #(
        .MAX_FRAME (MAX_FRAME)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_fire),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .o_snap  (snap)
    );

    // Status with short frame over CRC mismatch over wrong byte count.
    always_comb begin
        priority if (snap.short_frame) begin
            n_status = mrc_pkg::ST_SHORT;
        end else if (snap.held_lo != snap.crc[7:0] || snap.held_hi != snap.crc[15:8]) begin
            n_status = mrc_pkg::ST_CRC_ERR;
        end else if (snap.count != r_expected_count) begin
            n_status = mrc_pkg::ST_COUNT_ERR;
        end else begin
            n_status = mrc_pkg::ST_OK;
        end
    end

    // Data words and their value in ten-thousandths.
    assign n_iw     = {snap.data[0], snap.data[1]};
    assign n_fw     = {snap.data[2], snap.data[3]};
    assign n_scaled = ({14'd0, n_iw} * {16'd0, mrc_pkg::SCALE}) + {14'd0, n_fw};

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_status        <= n_status;
            r_integer_word  <= n_iw;
            r_fraction_word <= n_fw;
            r_scaled_value  <= n_scaled;
            r_computed_crc  <= snap.crc;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_integer_word  = r_integer_word;
    assign o_fraction_word = r_fraction_word;
    assign o_scaled_value  = r_scaled_value;
    assign o_computed_crc  = r_computed_crc;

`ifndef SYNTHESIS
    // A result beat only starts after a last byte left stage one.
    a_result_from_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("result beat without a last byte");

    // A last byte blocked by a waiting result stays in stage one.
    a_last_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && r_out_valid && !i_out_ready)
        |=> (r_s1_valid && r_s1_last))
        else $error("last byte dropped while output stalled");

    // The scaled value matches the reported words.
    a_scaled_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_scaled_value ==
            ({14'd0, r_integer_word} * 30'd10000) + {14'd0, r_fraction_word}))
        else $error("scaled value does not match data words");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response checker testbench
// Sends response frames byte by byte into the checker and compares every
// result beat against an in-bench model of the frame check: a short directed
// table first, then random frames across several byte count settings, with
// bursty input and a stalling result receiver.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAME_CAP     = 256;
    localparam int TARGET_BYTES  = 1550;
    localparam int PHASE_BYTES   = 220;
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES  = 200000;

    // One result beat as the checker reports it.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] int_word;
        logic [15:0] frac_word;
        logic [29:0] scaled;
        logic [15:0] crc;
    } t_result;

    // Directed table entries: a literal byte or one of the two CRC bytes.
    typedef enum {K_DATA, K_CRC_LO, K_CRC_HI} t_kind;

    typedef struct {
        t_kind       kind;
        logic [7:0]  value;
        logic        last;
        bit          pinned;
        t_result     fixed;
    } t_step;

    // Kinds of random frames.
    typedef enum {F_GOOD, F_BAD_CRC, F_BAD_COUNT, F_SHORT, F_NOISE} t_shape;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_frame_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_integer_word;
    logic [15:0] o_fraction_word;
    logic [29:0] o_scaled_value;
    logic [15:0] o_computed_crc;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_expected_count = 8'h00;

    modbus_rtu_response_checker_unit #(
        .MAX_FRAME(FRAME_CAP)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_rx_byte           (i_rx_byte),
        .i_frame_end         (i_frame_end),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_integer_word      (o_integer_word),
        .o_fraction_word     (o_fraction_word),
        .o_scaled_value      (o_scaled_value),
        .o_computed_crc      (o_computed_crc),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_expected_count(i_cfg_expected_count)
    );

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Frame check model state.
    logic [7:0]  exp_count = 8'd4;
    logic [15:0] acc_crc = mrc_pkg::CRC_INIT;
    logic [7:0]  line_old = 8'h00;
    logic [7:0]  line_new = 8'h00;
    logic [8:0]  seen_count = '0;
    logic [7:0]  count_field = 8'h00;
    logic [7:0]  data_field [4] = '{8'h00, 8'h00, 8'h00, 8'h00};

    t_result     expected_results [$];
    t_step       script [$];

    int          bytes_sent = 0;
    int          results_seen = 0;
    int          check_failures = 0;
    int          cfg_writes = 0;
    int          status_tally [4] = '{0, 0, 0, 0};
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          sender_idles = 1'b1;
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [3:0]  ready_phase = '0;

    // Byte-wise CRC-16/Modbus over the reflected polynomial.
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ mrc_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    // Takes one byte into the model; returns 1 with the result on the last byte.
    function automatic bit absorb_byte(input logic [7:0] b, input logic last,
                                       output t_result r);
        logic [8:0]  pos;
        logic [15:0] iw;
        logic [15:0] fw;
        pos = seen_count;
        r = '0;
        // The byte leaving the two-byte delay line enters the CRC.
        if (pos >= 9'd2) acc_crc = crc16_step(acc_crc, line_old);
        line_old = line_new;
        line_new = b;
        if (pos == 9'd2) count_field = b;
        else if (pos >= 9'd3 && pos <= 9'd6) data_field[pos - 9'd3] = b;
        if (seen_count < 9'(FRAME_CAP)) seen_count++;
        if (!last) return 1'b0;

        // Status priority: short frame, then CRC, then byte count.
        if (seen_count < 9'(mrc_pkg::MIN_FRAME))
            r.status = mrc_pkg::ST_SHORT;
        else if (line_old != acc_crc[7:0] || line_new != acc_crc[15:8])
            r.status = mrc_pkg::ST_CRC_ERR;
        else if (count_field != exp_count)
            r.status = mrc_pkg::ST_COUNT_ERR;
        else
            r.status = mrc_pkg::ST_OK;
        iw = {data_field[0], data_field[1]};
        fw = {data_field[2], data_field[3]};
        r.int_word  = iw;
        r.frac_word = fw;
        r.scaled    = 30'(32'(iw) * 32'd10000 + 32'(fw));
        r.crc       = acc_crc;

        // Clear the frame state for the next frame.
        acc_crc     = mrc_pkg::CRC_INIT;
        line_old    = 8'h00;
        line_new    = 8'h00;
        seen_count  = '0;
        count_field = 8'h00;
        data_field  = '{8'h00, 8'h00, 8'h00, 8'h00};
        return 1'b1;
    endfunction

    // Sends one byte beat, with bursts and gaps, and queues its result if any.
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input bit pinned, input t_result fixed);
        int      gap;
        bit      taken;
        t_result r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_idles ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_rx_byte   <= b;
        i_frame_end <= last;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        bytes_sent++;
        if (absorb_byte(b, last, r)) expected_results.push_back(pinned ? fixed : r);
    endtask

    // Sends one random frame of the given shape and length.
    task automatic send_frame(input t_shape shape, input int len);
        logic [15:0] c;
        logic [7:0]  b;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  cnt;
        int          body;
        c = mrc_pkg::CRC_INIT;
        cnt = (shape == F_BAD_COUNT) ? (exp_count ^ 8'($urandom_range(1, 255))) : exp_count;
        body = (shape == F_NOISE || len < 3) ? len : len - 2;
        for (int i = 0; i < body; i++) begin
            b = (i == 2 && shape != F_NOISE) ? cnt : 8'($urandom);
            send_byte(b, i == len - 1, 1'b0, '0);
            c = crc16_step(c, b);
        end
        // CRC trailer, low byte first, corrupted for bad-CRC frames.
        if (body < len) begin
            lo = c[7:0];
            hi = c[15:8];
            if (shape == F_BAD_CRC) begin
                case ($urandom_range(0, 2))
                    0: begin
                        lo = lo ^ 8'($urandom_range(1, 255));
                    end
                    1: begin
                        hi = hi ^ 8'($urandom_range(1, 255));
                    end
                    default: begin
                        {lo, hi} = {hi, lo};
                    end
                endcase
            end
            send_byte(lo, 1'b0, 1'b0, '0);
            send_byte(hi, 1'b1, 1'b0, '0);
        end
    endtask

    // Writes the byte count register once all pending results have drained.
    task automatic set_expected_count(input logic [7:0] v);
        bit taken;
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid          <= 1'b1;
        i_cfg_expected_count <= v;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        exp_count = v;
        cfg_writes++;
    endtask

    task automatic add_step(input t_kind kind, input logic [7:0] v, input logic last);
        script.push_back('{kind, v, last, 1'b0, '0});
    endtask

    // Result receiver: stalls on a rotating pattern.
    always @(posedge i_clk) begin
        i_out_ready <= ready_pattern[ready_phase];
        ready_phase <= ready_phase + 4'd1;
    end

    // Result checker: sampled on the falling edge before the accepting edge.
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                check_failures++;
                if (check_failures <= 10)
                    $display("Unexpected result beat at %0t: status %0d crc %h",
                             $realtime, o_status, o_computed_crc);
            end else begin
                want = expected_results.pop_front();
                status_tally[want.status]++;
                if (o_status !== want.status || o_integer_word !== want.int_word ||
                    o_fraction_word !== want.frac_word || o_scaled_value !== want.scaled ||
                    o_computed_crc !== want.crc) begin
                    check_failures++;
                    if (check_failures <= 10) begin
                        $display("Mismatch at %0t, expected/actual: status %0d/%0d int %h/%h",
                                 $realtime, want.status, o_status,
                                 want.int_word, o_integer_word);
                        $display("  frac %h/%h scaled %0d/%0d crc %h/%h",
                                 want.frac_word, o_fraction_word,
                                 want.scaled, o_scaled_value,
                                 want.crc, o_computed_crc);
                    end
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Run limit of %0d cycles reached with %0d results pending",
                     LIMIT_CYCLES, expected_results.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        logic [15:0] run_crc;
        logic [7:0]  b;
        logic [7:0]  v;
        int          phase;
        int          phase_end;
        int          pick;
        int          len;

        // One-byte frame: short, nothing captured, CRC untouched.
        script.push_back('{K_DATA, 8'h00, 1'b1, 1'b1,
                           '{mrc_pkg::ST_SHORT, 16'h0000, 16'h0000, 30'd0, 16'hFFFF}});
        // Good frame with all-ones data at the reset byte count.
        add_step(K_DATA, 8'h01, 1'b0);
        add_step(K_DATA, 8'h03, 1'b0);
        add_step(K_DATA, 8'h04, 1'b0);
        add_step(K_DATA, 8'hFF, 1'b0);
        add_step(K_DATA, 8'hFF, 1'b0);
        add_step(K_DATA, 8'hFF, 1'b0);
        add_step(K_DATA, 8'hFF, 1'b0);
        add_step(K_CRC_LO, 8'h00, 1'b0);
        add_step(K_CRC_HI, 8'h00, 1'b1);
        // Eight-byte frame, correct CRC, wrong byte count.
        add_step(K_DATA, 8'h11, 1'b0);
        add_step(K_DATA, 8'h22, 1'b0);
        add_step(K_DATA, 8'hFF, 1'b0);
        add_step(K_DATA, 8'hAA, 1'b0);
        add_step(K_DATA, 8'h55, 1'b0);
        add_step(K_DATA, 8'h00, 1'b0);
        add_step(K_CRC_LO, 8'h00, 1'b0);
        add_step(K_CRC_HI, 8'h00, 1'b1);
        // CRC bytes in the wrong order together with a wrong count: CRC wins.
        add_step(K_DATA, 8'h7F, 1'b0);
        add_step(K_DATA, 8'h80, 1'b0);
        add_step(K_DATA, 8'h00, 1'b0);
        add_step(K_DATA, 8'h01, 1'b0);
        add_step(K_DATA, 8'h02, 1'b0);
        add_step(K_DATA, 8'h03, 1'b0);
        add_step(K_CRC_HI, 8'h00, 1'b0);
        add_step(K_CRC_LO, 8'h00, 1'b1);

        // Hold reset, then release it.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        run_crc = mrc_pkg::CRC_INIT;
        foreach (script[i]) begin
            case (script[i].kind)
                K_CRC_LO: begin
                    b = run_crc[7:0];
                end
                K_CRC_HI: begin
                    b = run_crc[15:8];
                end
                default: begin
                    b = script[i].value;
                end
            endcase
            send_byte(b, script[i].last, script[i].pinned, script[i].fixed);
            if (script[i].last) run_crc = mrc_pkg::CRC_INIT;
            else if (script[i].kind == K_DATA) run_crc = crc16_step(run_crc, b);
        end

        // Random phases, each under its own byte count setting and idle pattern.
        phase = 0;
        while (bytes_sent < TARGET_BYTES) begin
            case (phase)
                0: v = 8'h00;
                1: v = 8'hFF;
                2: v = 8'h04;
                default: v = 8'($urandom);
            endcase
            set_expected_count(v);
            sender_idles = (phase % 3) != 2;
            ready_pattern = (phase % 4 == 3) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            phase_end = bytes_sent + PHASE_BYTES;
            // Overlong frame past the length counter's saturation point.
            if (phase == 1 || phase == 4)
                send_frame(F_GOOD, $urandom_range(FRAME_CAP + 1, FRAME_CAP + 40));
            while (bytes_sent < phase_end && bytes_sent < TARGET_BYTES) begin
                pick = $urandom_range(0, 99);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                  : $urandom_range(8, 16);
                if (pick < 60) send_frame(F_GOOD, len);
                else if (pick < 75) send_frame(F_BAD_CRC, len);
                else if (pick < 85) send_frame(F_BAD_COUNT, len);
                else if (pick < 93) send_frame(F_SHORT, $urandom_range(1, 7));
                else send_frame(F_NOISE, $urandom_range(1, 30));
            end
            phase++;
        end

        // Drain and let the pipeline settle.
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes over %0d byte count settings; checked %0d result beats",
                 bytes_sent, cfg_writes + 1, results_seen);
        $display("Results by status: ok %0d, short %0d, crc %0d, count %0d; failures %0d",
                 status_tally[mrc_pkg::ST_OK], status_tally[mrc_pkg::ST_SHORT],
                 status_tally[mrc_pkg::ST_CRC_ERR], status_tally[mrc_pkg::ST_COUNT_ERR],
                 check_failures);
        if (check_failures == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
